FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file gspr_check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while the reset is high
`define GSPR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define GSPR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/gspr_pkg.sv
// ----------------------------------------------------------------------------
// gspr_pkg
// Shared types and constants of the Gaussian spot patch renderer.
// ----------------------------------------------------------------------------
package gspr_pkg;

   typedef enum logic [1:0] {
      ACT_LOAD_EXP = 2'd0,
      ACT_LOAD_ABS = 2'd1,
      ACT_RENDER   = 2'd2
   } gspr_action_type;

   localparam logic [15:0] GAIN_AMPLITUDE_RESET = 16'd651;
   localparam logic [15:0] GAIN_SPREAD_RESET    = 16'd2048;
   localparam logic [1:0]  DECAY_RADIUS_RESET   = 2'd3;
   localparam logic [9:0]  LAST_COLUMN_RESET    = 10'd255;
   localparam logic [9:0]  LAST_ROW_RESET       = 10'd255;

   typedef struct packed {
      logic [15:0] gain_amplitude;
      logic [15:0] gain_spread;
      logic [1:0]  decay_radius;
      logic [9:0]  last_column;
      logic [9:0]  last_row;
   } gspr_cfg_type;

   typedef struct packed {
      logic        exp_we;
      logic        abs_we;
      logic [9:0]  index;
      logic [23:0] word;
   } gspr_load_type;

   typedef struct packed {
      logic              valid;
      logic [9:0]        px;
      logic [9:0]        py;
      logic signed [9:0] dx;
      logic signed [9:0] dy;
      logic              last;
   } gspr_pix_type;

   typedef struct packed {
      logic [9:0] px;
      logic [9:0] py;
      logic       last;
   } gspr_tag_type;

   typedef struct packed {
      logic        valid;
      logic [9:0]  pixel_x;
      logic [9:0]  pixel_y;
      logic [23:0] pixel_value;
      logic        last_pixel;
   } gspr_rsp_type;

endpackage

FILE: sv/gspr_req_if.sv
// ----------------------------------------------------------------------------
// gspr_req_if
// Input channel: table loads and render requests.
// ----------------------------------------------------------------------------
interface gspr_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic [9:0]         table_index;
   logic signed [23:0] table_word;
   logic [15:0]        spot_x;
   logic [15:0]        spot_y;

   modport source (output valid, action, table_index, table_word, spot_x, spot_y,
                   input ready);
   modport sink (input valid, action, table_index, table_word, spot_x, spot_y,
                 output ready);
endinterface

FILE: sv/gspr_rsp_if.sv
// ----------------------------------------------------------------------------
// gspr_rsp_if
// Result channel: one rendered pixel per transfer.
// ----------------------------------------------------------------------------
interface gspr_rsp_if;
   logic        valid;
   logic        ready;
   logic [9:0]  pixel_x;
   logic [9:0]  pixel_y;
   logic [23:0] pixel_value;
   logic        last_pixel;

   modport source (output valid, pixel_x, pixel_y, pixel_value, last_pixel,
                   input ready);
   modport sink (input valid, pixel_x, pixel_y, pixel_value, last_pixel,
                 output ready);
endinterface

FILE: sv/gspr_csr.sv
// ----------------------------------------------------------------------------
// gspr_csr
// APB register file holding gains, window radius and image bounds.
// ----------------------------------------------------------------------------
module gspr_csr
   import gspr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [4:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready,
   output gspr_cfg_type cfg
);

   localparam logic [2:0] CSR_GAIN_AMPLITUDE = 3'd0;
   localparam logic [2:0] CSR_GAIN_SPREAD    = 3'd1;
   localparam logic [2:0] CSR_DECAY_RADIUS   = 3'd2;
   localparam logic [2:0] CSR_LAST_COLUMN    = 3'd3;
   localparam logic [2:0] CSR_LAST_ROW       = 3'd4;

   gspr_cfg_type cfg_ff;
   gspr_cfg_type cfg_in;
   logic         write_en;

   assign write_en = psel && penable && pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (paddr[4:2])
            CSR_GAIN_AMPLITUDE: cfg_in.gain_amplitude = pwdata[15:0];
            CSR_GAIN_SPREAD:    cfg_in.gain_spread    = pwdata[15:0];
            CSR_DECAY_RADIUS:   cfg_in.decay_radius   = pwdata[1:0];
            CSR_LAST_COLUMN:    cfg_in.last_column    = pwdata[9:0];
            CSR_LAST_ROW:       cfg_in.last_row       = pwdata[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         CSR_GAIN_AMPLITUDE: prdata = {16'b0, cfg_ff.gain_amplitude};
         CSR_GAIN_SPREAD:    prdata = {16'b0, cfg_ff.gain_spread};
         CSR_DECAY_RADIUS:   prdata = {30'b0, cfg_ff.decay_radius};
         CSR_LAST_COLUMN:    prdata = {22'b0, cfg_ff.last_column};
         CSR_LAST_ROW:       prdata = {22'b0, cfg_ff.last_row};
         default:            prdata = 32'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_amplitude <= GAIN_AMPLITUDE_RESET;
         cfg_ff.gain_spread    <= GAIN_SPREAD_RESET;
         cfg_ff.decay_radius   <= DECAY_RADIUS_RESET;
         cfg_ff.last_column    <= LAST_COLUMN_RESET;
         cfg_ff.last_row       <= LAST_ROW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: sv/gspr_table.sv
// ----------------------------------------------------------------------------
// gspr_table
// Exp value and abscissa memories: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gspr_table
   import gspr_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                           clock,
   input  gspr_load_type                  load,
   input  logic                           rd_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
   output logic [15:0]                    rd_exp,
   output logic [23:0]                    rd_abscissa
);

   localparam int AW = $clog2(TABLE_DEPTH);

   logic [15:0] exp_values    [TABLE_DEPTH];
   logic [23:0] exp_abscissae [TABLE_DEPTH];
   logic        in_range;
   logic [AW-1:0] wr_addr;

   assign in_range = 32'(load.index) < 32'(TABLE_DEPTH);
   assign wr_addr  = AW'(load.index);

   always_ff @(posedge clock) begin
      if (load.exp_we && in_range) begin
         exp_values[wr_addr] <= load.word[15:0];
      end
      if (load.abs_we && in_range) begin
         exp_abscissae[wr_addr] <= load.word;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_exp      <= exp_values[rd_addr];
         rd_abscissa <= exp_abscissae[rd_addr];
      end
   end

endmodule

FILE: sv/gspr_walk.sv
// ----------------------------------------------------------------------------
// gspr_walk
// Window sequencer: clips the spot window to the image and steps through it
// column by column, y fastest, one pixel per cycle while advance is high.
// ----------------------------------------------------------------------------
module gspr_walk
   import gspr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  gspr_cfg_type cfg,
   input  logic         start,
   input  logic [15:0]  spot_x,
   input  logic [15:0]  spot_y,
   input  logic         advance,
   output gspr_pix_type pix,
   output logic         busy
);

   logic        busy_ff, busy_in;
   logic [9:0]  col_ff, col_in;
   logic [9:0]  row_ff, row_in;
   logic [9:0]  col_last_ff, col_last_in;
   logic [9:0]  row_first_ff, row_first_in;
   logic [9:0]  row_last_ff, row_last_in;
   logic [15:0] sx_ff, sx_in;
   logic [15:0] sy_ff, sy_in;

   logic [9:0]  cx, cy, radius;
   logic [9:0]  first_col, first_row, last_col, last_row;
   logic [10:0] far_col, far_row;
   logic        empty;
   logic signed [16:0] x_diff, y_diff;

   always_comb begin
      cx        = spot_x[15:6];
      cy        = spot_y[15:6];
      radius    = 10'(cfg.decay_radius);
      first_col = (cx >= radius) ? cx - radius : 10'd0;
      first_row = (cy >= radius) ? cy - radius : 10'd0;
      far_col   = {1'b0, cx} + 11'(cfg.decay_radius) + 11'd1;
      far_row   = {1'b0, cy} + 11'(cfg.decay_radius) + 11'd1;
      last_col  = (far_col > {1'b0, cfg.last_column}) ? cfg.last_column : far_col[9:0];
      last_row  = (far_row > {1'b0, cfg.last_row}) ? cfg.last_row : far_row[9:0];
      empty     = (cfg.last_column < first_col) || (cfg.last_row < first_row);
   end

   always_comb begin
      busy_in      = busy_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      col_last_in  = col_last_ff;
      row_first_in = row_first_ff;
      row_last_in  = row_last_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      if (start) begin
         busy_in      = !empty;
         col_in       = first_col;
         row_in       = first_row;
         col_last_in  = last_col;
         row_first_in = first_row;
         row_last_in  = last_row;
         sx_in        = spot_x;
         sy_in        = spot_y;
      end else if (busy_ff && advance) begin
         if (row_ff == row_last_ff) begin
            row_in = row_first_ff;
            if (col_ff == col_last_ff) begin
               busy_in = 1'b0;
            end else begin
               col_in = col_ff + 10'd1;
            end
         end else begin
            row_in = row_ff + 10'd1;
         end
      end
   end

   // window offsets stay within a few pixels, so ten signed bits hold them
   assign x_diff = $signed({1'b0, col_ff, 6'b0}) - $signed({1'b0, sx_ff});
   assign y_diff = $signed({1'b0, row_ff, 6'b0}) - $signed({1'b0, sy_ff});

   always_comb begin
      pix.valid = busy_ff;
      pix.px    = col_ff;
      pix.py    = row_ff;
      pix.dx    = x_diff[9:0];
      pix.dy    = y_diff[9:0];
      pix.last  = (col_ff == col_last_ff) && (row_ff == row_last_ff);
   end

   assign busy = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff       <= col_in;
      row_ff       <= row_in;
      col_last_ff  <= col_last_in;
      row_first_ff <= row_first_in;
      row_last_ff  <= row_last_in;
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
   end

endmodule

FILE: sv/gspr_weight.sv
// ----------------------------------------------------------------------------
// gspr_weight
// Pixel weight pipeline: squared distance, exponent scaling, table lookup,
// first-order correction, amplitude, rounding and the output register.
// ----------------------------------------------------------------------------
module gspr_weight
   import gspr_pkg::*;
#(
   parameter int TABLE_DEPTH    = 1024,
   parameter int STEPS_PER_UNIT = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  gspr_cfg_type                   cfg,
   input  gspr_pix_type                   pix,
   output logic                           advance,
   output logic                           reads_pending,
   output logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
   input  logic [15:0]                    rd_exp,
   input  logic [23:0]                    rd_abscissa,
   output gspr_rsp_type                   rsp,
   input  logic                           rsp_ready
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int SW = 34 + $clog2(STEPS_PER_UNIT + 1);
   localparam int IW = SW - 24;
   localparam logic [IW-1:0] INDEX_MAX  = IW'(TABLE_DEPTH - 1);
   localparam logic [56:0]   ROUND_HALF = 57'(1) << 27;

   logic              v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   gspr_tag_type      tag1_ff, tag2_ff, tag3_ff, tag4_ff, tag5_ff, tag6_ff, tag7_ff;
   logic signed [9:0] dx1_ff, dy1_ff;
   logic [17:0]       rr2_ff, rr2_in;
   logic [33:0]       prod3_ff, prod3_in;
   logic              oob4_ff, oob4_in, oob5_ff, oob6_ff, oob7_ff;
   logic [AW-1:0]     addr4_ff, addr4_in;
   logic [25:0]       d16_4_ff, d16_5_ff;
   logic [31:0]       ae6_ff, ae6_in;
   logic [23:0]       f6_ff, f6_in;
   logic [55:0]       prod7_ff, prod7_in;
   gspr_rsp_type      rsp_ff, rsp_in;

   logic signed [19:0] sqx, sqy;
   logic [SW-1:0]      scaled;
   logic [IW-1:0]      step_index;
   logic signed [27:0] factor;
   logic [56:0]        rounded;
   logic [28:0]        quotient;

   assign advance       = !rsp_ff.valid || rsp_ready;
   assign reads_pending = v1_ff || v2_ff || v3_ff || v4_ff;
   assign rd_addr       = addr4_ff;
   assign rsp           = rsp_ff;

   always_comb begin
      sqx    = dx1_ff * dx1_ff;
      sqy    = dy1_ff * dy1_ff;
      rr2_in = 18'(sqx) + 18'(sqy);
   end

   assign prod3_in = {18'b0, cfg.gain_spread} * {16'b0, rr2_ff};

   always_comb begin
      scaled     = SW'(prod3_ff) * SW'(STEPS_PER_UNIT);
      step_index = scaled[SW-1:24];
      oob4_in    = step_index > INDEX_MAX;
      addr4_in   = AW'(step_index);
   end

   always_comb begin
      factor = 28'sd65536 - $signed({2'b0, d16_5_ff})
               - $signed({{4{rd_abscissa[23]}}, rd_abscissa});
      f6_in  = factor[27] ? 24'd0 : factor[23:0];
      ae6_in = {16'b0, cfg.gain_amplitude} * {16'b0, rd_exp};
   end

   assign prod7_in = {24'b0, ae6_ff} * {32'b0, f6_ff};

   always_comb begin
      rounded            = {1'b0, prod7_ff} + ROUND_HALF;
      quotient           = rounded[56:28];
      rsp_in.valid       = v7_ff;
      rsp_in.pixel_x     = tag7_ff.px;
      rsp_in.pixel_y     = tag7_ff.py;
      rsp_in.last_pixel  = tag7_ff.last;
      if (oob7_ff) begin
         rsp_in.pixel_value = 24'd0;
      end else if (|quotient[28:24]) begin
         rsp_in.pixel_value = 24'hFFFFFF;
      end else begin
         rsp_in.pixel_value = quotient[23:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         rsp_ff.valid <= 1'b0;
      end else if (advance) begin
         v1_ff        <= pix.valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         v7_ff        <= v6_ff;
         rsp_ff.valid <= rsp_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tag1_ff  <= '{px: pix.px, py: pix.py, last: pix.last};
         dx1_ff   <= pix.dx;
         dy1_ff   <= pix.dy;
         tag2_ff  <= tag1_ff;
         rr2_ff   <= rr2_in;
         tag3_ff  <= tag2_ff;
         prod3_ff <= prod3_in;
         tag4_ff  <= tag3_ff;
         oob4_ff  <= oob4_in;
         addr4_ff <= addr4_in;
         d16_4_ff <= prod3_ff[33:8];
         tag5_ff  <= tag4_ff;
         oob5_ff  <= oob4_ff;
         d16_5_ff <= d16_4_ff;
         tag6_ff  <= tag5_ff;
         oob6_ff  <= oob5_ff;
         ae6_ff   <= ae6_in;
         f6_ff    <= f6_in;
         tag7_ff  <= tag6_ff;
         oob7_ff  <= oob6_ff;
         prod7_ff <= prod7_in;
         rsp_ff.pixel_x     <= rsp_in.pixel_x;
         rsp_ff.pixel_y     <= rsp_in.pixel_y;
         rsp_ff.pixel_value <= rsp_in.pixel_value;
         rsp_ff.last_pixel  <= rsp_in.last_pixel;
      end
   end

endmodule

FILE: sv/gaussian_spot_patch_render_core.sv
// ----------------------------------------------------------------------------
// gaussian_spot_patch_render_core
// Renders a Gaussian spot window from loaded exp and abscissa tables.
//
//   channel   direction  transfer carries
//   req_bus   in         action, table_index, table_word, spot_x, spot_y
//   rsp_bus   out        pixel_x, pixel_y, pixel_value, last_pixel
//   apb       in/out     gain_amplitude, gain_spread, decay_radius,
//                        last_column, last_row
//
// A load writes the table memory at its transfer.
// A render emits one pixel per cycle while the result channel does not stall,
// for up to 64 pixels. The next request is taken once the window sequencer is
// done and the four stages ahead of the table read port have drained.
// Reset is synchronous; the tables are not cleared. A stalled result stalls
// the whole pipeline.
// ----------------------------------------------------------------------------
module gaussian_spot_patch_render_core
   import gspr_pkg::*;
#(
   parameter int TABLE_DEPTH    = 1024,
   parameter int STEPS_PER_UNIT = 64
) (
   input  logic          clock,
   input  logic          reset,
   gspr_req_if.sink      req_bus,
   gspr_rsp_if.source    rsp_bus,
   input  logic          psel,
   input  logic          penable,
   input  logic          pwrite,
   input  logic [4:0]    paddr,
   input  logic [31:0]   pwdata,
   output logic [31:0]   prdata,
   output logic          pready
);

   localparam int AW = $clog2(TABLE_DEPTH);

   gspr_cfg_type  cfg;
   gspr_load_type load;
   gspr_pix_type  pix;
   gspr_rsp_type  rsp;
   logic          accept;
   logic          start;
   logic          walk_busy;
   logic          advance;
   logic          reads_pending;
   logic [AW-1:0] rd_addr;
   logic [15:0]   rd_exp;
   logic [23:0]   rd_abscissa;

   assign req_bus.ready = !walk_busy && !reads_pending;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      load.exp_we = 1'b0;
      load.abs_we = 1'b0;
      load.index  = req_bus.table_index;
      load.word   = req_bus.table_word;
      start       = 1'b0;
      if (accept) begin
         case (gspr_action_type'(req_bus.action))
            ACT_LOAD_EXP: load.exp_we = 1'b1;
            ACT_LOAD_ABS: load.abs_we = 1'b1;
            ACT_RENDER:   start       = 1'b1;
            default: ;
         endcase
      end
   end

   gspr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   gspr_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock       (clock),
      .load        (load),
      .rd_en       (advance),
      .rd_addr     (rd_addr),
      .rd_exp      (rd_exp),
      .rd_abscissa (rd_abscissa)
   );

   gspr_walk u_walk (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .start   (start),
      .spot_x  (req_bus.spot_x),
      .spot_y  (req_bus.spot_y),
      .advance (advance),
      .pix     (pix),
      .busy    (walk_busy)
   );

   gspr_weight #(
      .TABLE_DEPTH    (TABLE_DEPTH),
      .STEPS_PER_UNIT (STEPS_PER_UNIT)
   ) u_weight (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .pix           (pix),
      .advance       (advance),
      .reads_pending (reads_pending),
      .rd_addr       (rd_addr),
      .rd_exp        (rd_exp),
      .rd_abscissa   (rd_abscissa),
      .rsp           (rsp),
      .rsp_ready     (rsp_bus.ready)
   );

   assign rsp_bus.valid       = rsp.valid;
   assign rsp_bus.pixel_x     = rsp.pixel_x;
   assign rsp_bus.pixel_y     = rsp.pixel_y;
   assign rsp_bus.pixel_value = rsp.pixel_value;
   assign rsp_bus.last_pixel  = rsp.last_pixel;

endmodule

FILE: sv/gspr_check.sv
// ----------------------------------------------------------------------------
// gspr_check
// Port-level checks on the result channel of the spot renderer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gspr_check (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [9:0]  pixel_x,
   input logic [9:0]  pixel_y,
   input logic [23:0] pixel_value,
   input logic        last_pixel
);

   `GSPR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(pixel_value) && $stable(last_pixel), "result changed while stalled")

   `GSPR_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "result valid after reset")

   `GSPR_ASSERT(a_window_order, clock, reset, rsp_valid && $past(rsp_valid && rsp_ready && !last_pixel) |-> (pixel_x == $past(pixel_x) && pixel_y == $past(pixel_y) + 10'd1) || (pixel_x == $past(pixel_x) + 10'd1), "window pixels out of order")

endmodule

bind gaussian_spot_patch_render_core gspr_check u_gspr_check (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .pixel_x     (rsp_bus.pixel_x),
   .pixel_y     (rsp_bus.pixel_y),
   .pixel_value (rsp_bus.pixel_value),
   .last_pixel  (rsp_bus.last_pixel)
);

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Gaussian spot patch renderer testbench. A queue of loads, renders and
// unused codes feeds a clocked driver. Table entries are loaded before any
// render reads them. A shadow of the tables and registers predicts every
// window pixel when the request is accepted, and the result monitor checks
// each transfer in order. The run steps through several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import gspr_pkg::*;

   localparam int TABLE_DEPTH    = 1024;
   localparam int STEPS_PER_UNIT = 64;
   localparam int POS_ONE        = 64;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam int REG_GAIN_AMPLITUDE = 0;
   localparam int REG_GAIN_SPREAD    = 1;
   localparam int REG_DECAY_RADIUS   = 2;
   localparam int REG_LAST_COLUMN    = 3;
   localparam int REG_LAST_ROW       = 4;
   localparam int NUM_REGS           = 5;

   localparam longint VALUE_MAX     = 64'hFFFFFF;
   localparam int     MAX_GAP       = 13;
   localparam int     SETTLE_CYCLES = 20;
   localparam int     HOLD_CYCLES   = 400;
   localparam int     REPORT_LIMIT  = 100;
   localparam longint CYCLE_LIMIT   = 2_000_000;

   typedef struct {
      logic [1:0]  action;
      logic [9:0]  table_index;
      logic [23:0] table_word;
      logic [15:0] spot_x;
      logic [15:0] spot_y;
      bit          drain_first;
   } spot_request_t;

   typedef struct {
      logic [9:0]  x;
      logic [9:0]  y;
      logic [23:0] value;
      logic        last;
   } spot_pixel_t;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   gspr_req_if req_bus();
   gspr_rsp_if rsp_bus();

   gaussian_spot_patch_render_core #(
      .TABLE_DEPTH    (TABLE_DEPTH),
      .STEPS_PER_UNIT (STEPS_PER_UNIT)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   gspr_cfg_type       render_cfg;
   logic [15:0]        exp_table [TABLE_DEPTH];
   logic signed [23:0] abscissa_table [TABLE_DEPTH];
   bit                 exp_loaded [TABLE_DEPTH];
   bit                 abscissa_loaded [TABLE_DEPTH];

   spot_request_t pending_requests[$];
   spot_pixel_t   expected_pixels[$];
   spot_request_t next_req;
   spot_pixel_t   want_pixel;

   int     mismatch_count = 0;
   int     pixels_checked = 0;
   longint cycle_count    = 0;
   bit     req_took       = 0;
   bit     rsp_took       = 0;
   bit     offering       = 0;
   bit     rsp_hold       = 0;
   bit     drain_next     = 0;
   bit     gap_drawn      = 0;
   bit     send_eager     = 0;
   bit     recv_eager     = 0;
   int     send_gap       = 0;
   int     ready_gap      = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset           = 1'b1;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      req_bus.valid   = 1'b0;
      req_bus.action  = ACT_LOAD_EXP;
      req_bus.table_index = '0;
      req_bus.table_word  = '0;
      req_bus.spot_x  = '0;
      req_bus.spot_y  = '0;
      rsp_bus.ready   = 1'b0;
      render_cfg = '{GAIN_AMPLITUDE_RESET, GAIN_SPREAD_RESET, DECAY_RADIUS_RESET,
                     LAST_COLUMN_RESET, LAST_ROW_RESET};
      repeat (12) @(negedge clock);
      reset <= 1'b0;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("tb: mismatch: %s", what);
      end
   endtask

   // spread gain times squared distance, Q.24
   function automatic longint spread_product(input int px, input int py,
                                             input logic [15:0] sx, input logic [15:0] sy);
      longint dx;
      longint dy;
      dx = longint'(px) * POS_ONE - longint'(sx);
      dy = longint'(py) * POS_ONE - longint'(sy);
      return longint'(render_cfg.gain_spread) * (dx * dx + dy * dy);
   endfunction

   function automatic longint table_slot(input longint prod);
      return (prod * STEPS_PER_UNIT) >>> 24;
   endfunction

   function automatic logic [23:0] spot_weight(input int px, input int py,
                                               input logic [15:0] sx, input logic [15:0] sy);
      longint prod;
      longint slot;
      longint factor;
      longint level;
      prod = spread_product(px, py, sx, sy);
      slot = table_slot(prod);
      if (slot > TABLE_DEPTH - 1) return '0;
      factor = 64'sd65536 - (prod >>> 8) - longint'(abscissa_table[slot]);
      if (factor < 0) factor = 0;
      level = longint'(render_cfg.gain_amplitude) * longint'(exp_table[slot]) * factor;
      level = (level + (longint'(1) <<< 27)) >>> 28;
      if (level > VALUE_MAX) level = VALUE_MAX;
      return level[23:0];
   endfunction

   // window bounds, upper bounds exclusive
   task automatic window_bounds(input logic [15:0] sx, input logic [15:0] sy,
                                output int lo_x, output int hi_x,
                                output int lo_y, output int hi_y);
      int r;
      r = int'(render_cfg.decay_radius);
      lo_x = int'(sx[15:6]) - r;
      lo_y = int'(sy[15:6]) - r;
      hi_x = int'(sx[15:6]) + r + 2;
      hi_y = int'(sy[15:6]) + r + 2;
      if (lo_x < 0) lo_x = 0;
      if (lo_y < 0) lo_y = 0;
      if (hi_x > int'(render_cfg.last_column) + 1) hi_x = int'(render_cfg.last_column) + 1;
      if (hi_y > int'(render_cfg.last_row) + 1) hi_y = int'(render_cfg.last_row) + 1;
   endtask

   task automatic render_spot(input logic [15:0] sx, input logic [15:0] sy);
      int lo_x;
      int hi_x;
      int lo_y;
      int hi_y;
      spot_pixel_t px;
      window_bounds(sx, sy, lo_x, hi_x, lo_y, hi_y);
      for (int i = lo_x; i < hi_x; i++) begin
         for (int j = lo_y; j < hi_y; j++) begin
            px.x     = i[9:0];
            px.y     = j[9:0];
            px.value = spot_weight(i, j, sx, sy);
            px.last  = (i == hi_x - 1) && (j == hi_y - 1);
            expected_pixels.push_back(px);
         end
      end
   endtask

   task automatic push_request(input logic [1:0] action, input logic [9:0] index,
                               input logic [23:0] word, input logic [15:0] sx,
                               input logic [15:0] sy);
      spot_request_t item;
      item.action      = action;
      item.table_index = index;
      item.table_word  = word;
      item.spot_x      = sx;
      item.spot_y      = sy;
      item.drain_first = drain_next;
      drain_next = 0;
      if (action == ACT_LOAD_EXP) exp_loaded[index] = 1;
      if (action == ACT_LOAD_ABS) abscissa_loaded[index] = 1;
      pending_requests.push_back(item);
   endtask

   // mostly close to the first-order abscissa of the slot
   function automatic logic [23:0] abscissa_word(input int slot);
      if ($urandom_range(0, 99) < 70) begin
         return 24'(-(slot * 1024) + int'($urandom_range(0, 4095)) - 2048);
      end
      return 24'($urandom);
   endfunction

   // loads every table slot the window reads that has no value yet, then renders
   task automatic add_render(input logic [15:0] sx, input logic [15:0] sy);
      int lo_x;
      int hi_x;
      int lo_y;
      int hi_y;
      longint slot;
      window_bounds(sx, sy, lo_x, hi_x, lo_y, hi_y);
      for (int i = lo_x; i < hi_x; i++) begin
         for (int j = lo_y; j < hi_y; j++) begin
            slot = table_slot(spread_product(i, j, sx, sy));
            if (slot <= TABLE_DEPTH - 1) begin
               if (!exp_loaded[slot]) begin
                  push_request(ACT_LOAD_EXP, slot[9:0], 24'($urandom), $urandom, $urandom);
               end
               if (!abscissa_loaded[slot]) begin
                  push_request(ACT_LOAD_ABS, slot[9:0], abscissa_word(int'(slot)),
                               $urandom, $urandom);
               end
            end
         end
      end
      push_request(ACT_RENDER, $urandom, $urandom, sx, sy);
   endtask

   function automatic logic [15:0] rand_coord(input logic [9:0] last);
      int top;
      top = (int'(last) + 2) * POS_ONE + POS_ONE - 1;
      if (top > 65535) top = 65535;
      if ($urandom_range(0, 99) < 85) return 16'($urandom_range(0, top));
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic add_random_items(input int count);
      int made;
      int pick;
      made = 0;
      while (made < count) begin
         if (made == count / 2) drain_next = 1;
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            add_render(rand_coord(render_cfg.last_column), rand_coord(render_cfg.last_row));
            made++;
         end else if (pick < 70) begin
            push_request(ACT_LOAD_EXP, $urandom, $urandom, $urandom, $urandom);
            made++;
         end else if (pick < 80) begin
            push_request(ACT_LOAD_ABS, $urandom, $urandom, $urandom, $urandom);
            made++;
         end else if (pick < 90) begin
            push_request(ACT_UNUSED, $urandom, $urandom, $urandom, $urandom);
         end else begin
            add_render($urandom, $urandom);
            made++;
         end
      end
   endtask

   task automatic csr_write(input int index, input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 5'(index * 4);
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (index)
         REG_GAIN_AMPLITUDE: render_cfg.gain_amplitude = value[15:0];
         REG_GAIN_SPREAD:    render_cfg.gain_spread    = value[15:0];
         REG_DECAY_RADIUS:   render_cfg.decay_radius   = value[1:0];
         REG_LAST_COLUMN:    render_cfg.last_column    = value[9:0];
         REG_LAST_ROW:       render_cfg.last_row       = value[9:0];
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic csr_check(input int index);
      logic [31:0] want;
      logic [31:0] mask;
      logic [31:0] got;
      case (index)
         REG_GAIN_AMPLITUDE: begin want = render_cfg.gain_amplitude; mask = 32'hFFFF; end
         REG_GAIN_SPREAD:    begin want = render_cfg.gain_spread;    mask = 32'hFFFF; end
         REG_DECAY_RADIUS:   begin want = render_cfg.decay_radius;   mask = 32'h3;    end
         REG_LAST_COLUMN:    begin want = render_cfg.last_column;    mask = 32'h3FF;  end
         default:            begin want = render_cfg.last_row;       mask = 32'h3FF;  end
      endcase
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= 5'(index * 4);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      got = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if ((got & mask) !== want) begin
         report_mismatch($sformatf("register %0d read %0h want %0h", index, got & mask, want));
      end
   endtask

   task automatic apply_config(input gspr_cfg_type c);
      csr_write(REG_GAIN_AMPLITUDE, 32'(c.gain_amplitude));
      csr_write(REG_GAIN_SPREAD,    32'(c.gain_spread));
      csr_write(REG_DECAY_RADIUS,   32'(c.decay_radius));
      csr_write(REG_LAST_COLUMN,    32'(c.last_column));
      csr_write(REG_LAST_ROW,       32'(c.last_row));
      for (int i = 0; i < NUM_REGS; i++) csr_check(i);
   endtask

   // all requests taken, all pixels back, then let trailing loads settle
   task automatic wait_idle();
      while (pending_requests.size() != 0 || offering || expected_pixels.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(input gspr_cfg_type c, input int count);
      apply_config(c);
      @(posedge clock);
      add_render(16'd0, 16'd0);
      add_render(16'hFFFF, 16'hFFFF);
      add_render(16'hFFFF, 16'd0);
      add_render(16'd0, 16'hFFFF);
      add_random_items(count);
      wait_idle();
   endtask

   function automatic gspr_cfg_type random_cfg();
      gspr_cfg_type c;
      c.gain_amplitude = 16'($urandom);
      c.gain_spread    = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 4095))
                                                     : 16'($urandom);
      c.decay_radius   = 2'($urandom);
      c.last_column    = 10'($urandom);
      c.last_row       = 10'($urandom);
      return c;
   endfunction

   // stimulus and register phases
   initial begin
      while (reset) @(posedge clock);
      for (int i = 0; i < NUM_REGS; i++) csr_check(i);
      @(posedge clock);

      // factor near its largest, then clamped at zero, at the spot center
      push_request(ACT_LOAD_EXP, 10'd0, 24'h7FFFFF, 16'd0, 16'd0);
      push_request(ACT_LOAD_ABS, 10'd0, 24'h800000, 16'd0, 16'd0);
      add_render(16'd0, 16'd0);
      push_request(ACT_LOAD_ABS, 10'd0, 24'h7FFFFF, 16'hFFFF, 16'hFFFF);
      add_render(16'd0, 16'd0);
      push_request(ACT_LOAD_ABS, 10'd0, 24'h000000, 16'd0, 16'd0);
      push_request(ACT_LOAD_EXP, 10'd1023, 24'h800000, 16'hFFFF, 16'hFFFF);
      push_request(ACT_LOAD_ABS, 10'd1023, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
      push_request(ACT_UNUSED, 10'd1023, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
      add_render(16'hFFFF, 16'hFFFF);
      add_render(16'hFFFF, 16'd0);
      add_render(16'd0, 16'hFFFF);
      add_render(16'(255 * 64 + 63), 16'(100 * 64 + 1));
      add_render(16'(32 * 64 + 17), 16'(40 * 64 + 50));
      add_render(16'(128 * 64), 16'(255 * 64 + 63));
      add_random_items(40);
      wait_idle();

      run_phase('{16'hFFFF, 16'd0, 2'd0, 10'd1023, 10'd1023}, 70);
      run_phase('{16'd0, 16'hFFFF, 2'd3, 10'd0, 10'd0}, 70);
      run_phase('{16'd4096, 16'd700, 2'd2, 10'd1023, 10'd31}, 70);
      run_phase(random_cfg(), 70);
      run_phase(random_cfg(), 70);
      run_phase('{GAIN_AMPLITUDE_RESET, GAIN_SPREAD_RESET, DECAY_RADIUS_RESET,
                  LAST_COLUMN_RESET, LAST_ROW_RESET}, 70);

      if (mismatch_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         offering = 0;
      end else begin
         if (req_took) offering = 0;
         if (!offering && pending_requests.size() != 0) begin
            if (!gap_drawn) begin
               if ($urandom_range(0, 19) == 0) send_eager = !send_eager;
               send_gap  = send_eager ? 0 : $urandom_range(0, MAX_GAP);
               gap_drawn = 1;
            end
            if (send_gap > 0) begin
               send_gap--;
            end else if (!pending_requests[0].drain_first || expected_pixels.size() == 0) begin
               next_req  = pending_requests.pop_front();
               offering  = 1;
               gap_drawn = 0;
               req_bus.action      <= next_req.action;
               req_bus.table_index <= next_req.table_index;
               req_bus.table_word  <= next_req.table_word;
               req_bus.spot_x      <= next_req.spot_x;
               req_bus.spot_y      <= next_req.spot_y;
            end
         end
         req_bus.valid <= offering;
      end
   end

   // request monitor: update the table shadow or predict the window
   always @(posedge clock) begin
      req_took = 0;
      if (!reset && req_bus.valid && req_bus.ready) begin
         req_took = 1;
         case (req_bus.action)
            ACT_LOAD_EXP: exp_table[req_bus.table_index] = req_bus.table_word[15:0];
            ACT_LOAD_ABS: abscissa_table[req_bus.table_index] = req_bus.table_word;
            ACT_RENDER:   render_spot(req_bus.spot_x, req_bus.spot_y);
            default: ;
         endcase
      end
   end

   // result ready driver
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_took) begin
            if ($urandom_range(0, 19) == 0) recv_eager = !recv_eager;
            ready_gap = recv_eager ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (rsp_hold) begin
            rsp_bus.ready <= 1'b0;
         end else if (ready_gap > 0) begin
            ready_gap--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // long result stall so the pipeline backs up into the request side
   initial begin
      while (pixels_checked < 300) @(posedge clock);
      rsp_hold = 1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 0;
   end

   // result monitor
   always @(posedge clock) begin
      rsp_took = 0;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_took = 1;
         pixels_checked++;
         if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel x=%0d y=%0d",
                                      rsp_bus.pixel_x, rsp_bus.pixel_y));
         end else begin
            want_pixel = expected_pixels.pop_front();
            if (rsp_bus.pixel_x !== want_pixel.x) begin
               report_mismatch($sformatf("pixel_x got %0d want %0d",
                                         rsp_bus.pixel_x, want_pixel.x));
            end
            if (rsp_bus.pixel_y !== want_pixel.y) begin
               report_mismatch($sformatf("pixel_y got %0d want %0d",
                                         rsp_bus.pixel_y, want_pixel.y));
            end
            if (rsp_bus.pixel_value !== want_pixel.value) begin
               report_mismatch($sformatf("pixel_value at (%0d,%0d) got %0h want %0h",
                                         want_pixel.x, want_pixel.y,
                                         rsp_bus.pixel_value, want_pixel.value));
            end
            if (rsp_bus.last_pixel !== want_pixel.last) begin
               report_mismatch($sformatf("last_pixel at (%0d,%0d) got %0b want %0b",
                                         want_pixel.x, want_pixel.y,
                                         rsp_bus.last_pixel, want_pixel.last));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

endmodule
